// ===== hdl/cwad_pkg.sv =====
// ----------------------------------------------------------------------------
// cwad_pkg: shared types and constants for the wideband AFR decoder
// Register indexes, status codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package cwad_pkg;

  localparam logic [2:0] REG_MATCH_ID  = 3'd0;
  localparam logic [2:0] REG_WORD_OFF  = 3'd1;
  localparam logic [2:0] REG_EXPECT_EXT = 3'd2;
  localparam logic [2:0] REG_WORD_FMT  = 3'd3;
  localparam logic [2:0] REG_SCALE_NUM = 3'd4;
  localparam logic [2:0] REG_SCALE_DEN = 3'd5;
  localparam logic [2:0] REG_STOICH    = 3'd6;
  localparam logic [2:0] REG_TIMEOUT   = 3'd7;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_FRESH = 2'd1;
  localparam logic [1:0] STATUS_STALE = 2'd2;

  localparam int QUOT_W = 43;

  typedef struct packed {
    logic load;      // capture item and start
    logic mul1;      // raw*num
    logic mul2;      // *100
    logic div_start; // start divider on scaled product
    logic afr_set;   // register clamped afr
    logic mul3;      // afr*1000
    logic div2_start;
    logic commit;    // update held state
  } cwad_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic pass;
    logic div_done;
  } cwad_stat_t;

endpackage

// ===== hdl/cwad_divider.sv =====
// ----------------------------------------------------------------------------
// cwad_divider: restoring divider, one quotient bit per cycle
// Divides a 43-bit dividend by a 24-bit divisor.
// ----------------------------------------------------------------------------
module cwad_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cwad_pkg::QUOT_W-1:0]   dividend,
  input  logic [23:0]                   divisor,
  output logic                          done,
  output logic [cwad_pkg::QUOT_W-1:0]   quotient
);

  logic [5:0]                 count;
  logic                       busy;
  logic [24:0]                rem;
  logic [23:0]                dvs;
  logic [25:0]                trial;

  assign trial = {rem, quotient[cwad_pkg::QUOT_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'(cwad_pkg::QUOT_W);
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[25]) begin
        rem <= trial[24:0];
        quotient <= {quotient[cwad_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem <= {rem[23:0], quotient[cwad_pkg::QUOT_W-1]};
        quotient <= {quotient[cwad_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/cwad_datapath.sv =====
// ----------------------------------------------------------------------------
// cwad_datapath: filter, word extraction, scaling and held snapshot
// Runs the arithmetic under the controller's commands.
// ----------------------------------------------------------------------------
module cwad_datapath #(
  parameter int AFR_OFFSET = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cwad_pkg::cwad_cmd_t   cmd_ctl,
  output cwad_pkg::cwad_stat_t  stat,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  cmd,
  input  logic                  frame_extended,
  input  logic                  frame_remote,
  input  logic [28:0]           frame_identifier,
  input  logic [3:0]            length_code,
  input  logic [63:0]           payload,
  output logic [15:0]           afr_out_x100,
  output logic [15:0]           lambda_out_x1000,
  output logic [7:0]            voltage_out_x10,
  output logic [1:0]            status,
  output logic                  frame_accepted
);

  logic [28:0] match_identifier;
  logic [2:0]  word_offset;
  logic        expect_extended;
  logic [1:0]  word_format;
  logic [19:0] scale_numerator;
  logic [23:0] scale_denominator;
  logic [15:0] stoich_ratio;
  logic [15:0] timeout_ticks;

  logic [15:0] afr_held;
  logic [15:0] lambda_held;
  logic [7:0]  voltage_held;
  logic        ever_received;
  logic [15:0] age_count;

  logic        is_tick;
  logic        pass;
  logic [15:0] raw;
  logic [7:0]  volt;
  logic [35:0] prod;
  logic [42:0] prod2;
  logic [15:0] afr_new;
  logic [25:0] prod3;

  logic        div_start;
  logic [42:0] div_dividend;
  logic [23:0] div_divisor;
  logic        div_done;
  logic [42:0] div_q;

  logic [3:0]  len_c;
  logic [3:0]  need;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [2:0]  off1;
  logic        fresh;
  logic signed [44:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_identifier <= 29'd175;
      word_offset <= 3'd0;
      expect_extended <= 1'b1;
      word_format <= 2'd3;
      scale_numerator <= 20'd1465;
      scale_denominator <= 24'd1000000;
      stoich_ratio <= 16'd1465;
      timeout_ticks <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        cwad_pkg::REG_MATCH_ID:   match_identifier <= cfg_data[28:0];
        cwad_pkg::REG_WORD_OFF:   word_offset <= cfg_data[2:0];
        cwad_pkg::REG_EXPECT_EXT: expect_extended <= cfg_data[0];
        cwad_pkg::REG_WORD_FMT:   word_format <= cfg_data[1:0];
        cwad_pkg::REG_SCALE_NUM:  scale_numerator <= cfg_data[19:0];
        cwad_pkg::REG_SCALE_DEN:  scale_denominator <= cfg_data[23:0];
        cwad_pkg::REG_STOICH:     stoich_ratio <= cfg_data[15:0];
        cwad_pkg::REG_TIMEOUT:    timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign len_c = (length_code > 4'd8) ? 4'd8 : length_code;
  assign need  = {1'b0, word_offset} + (word_format[0] ? 4'd2 : 4'd1);
  assign off1  = word_offset + 3'd1;
  assign b0    = payload[{word_offset, 3'b000} +: 8];
  assign b1    = payload[{off1, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (cmd_ctl.load) begin
      is_tick <= cmd;
      pass <= !cmd && (frame_extended == expect_extended)
              && (frame_identifier == match_identifier)
              && !frame_remote && (need <= len_c);
      if (!word_format[0]) raw <= {8'd0, b0};
      else if (word_format[1]) raw <= {b0, b1};
      else raw <= {b1, b0};
      volt <= (len_c >= 4'd5) ? payload[39:32] : 8'd0;
    end
    if (cmd_ctl.mul1) prod <= 36'(raw) * 36'(scale_numerator);
    if (cmd_ctl.mul2) prod2 <= 43'(prod) * 43'd100;
    if (cmd_ctl.mul3) prod3 <= 26'(afr_new) * 26'd1000;
    if (cmd_ctl.afr_set) begin
      if (sum <= 0) afr_new <= 16'd0;
      else if (sum > 45'sd65535) afr_new <= 16'hFFFF;
      else afr_new <= sum[15:0];
    end
  end

  assign sum = $signed({2'b00, div_q}) + 45'(AFR_OFFSET);

  assign div_start    = cmd_ctl.div_start || cmd_ctl.div2_start;
  assign div_dividend = cmd_ctl.div_start ? prod2 : 43'(prod3);
  assign div_divisor  = cmd_ctl.div_start
                        ? ((scale_denominator == 24'd0) ? 24'd1 : scale_denominator)
                        : ((stoich_ratio == 16'd0) ? 24'd1 : 24'(stoich_ratio));

  cwad_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      afr_held <= '0;
      lambda_held <= '0;
      voltage_held <= '0;
      ever_received <= 1'b0;
      age_count <= '0;
    end else if (cmd_ctl.commit) begin
      if (is_tick) begin
        if (age_count != 16'hFFFF) age_count <= age_count + 16'd1;
      end else if (pass) begin
        afr_held <= afr_new;
        if (afr_new == 16'd0 || stoich_ratio == 16'd0) lambda_held <= 16'd0;
        else if (div_q > 43'd65535) lambda_held <= 16'hFFFF;
        else lambda_held <= div_q[15:0];
        voltage_held <= volt;
        ever_received <= 1'b1;
        age_count <= '0;
      end
    end
  end

  assign stat.is_tick = is_tick;
  assign stat.pass = pass;
  assign stat.div_done = div_done;

  always_comb begin
    if (!ever_received) status = cwad_pkg::STATUS_NONE;
    else if (age_count >= timeout_ticks) status = cwad_pkg::STATUS_STALE;
    else status = cwad_pkg::STATUS_FRESH;
  end
  assign fresh = (status == cwad_pkg::STATUS_FRESH);
  assign afr_out_x100 = fresh ? afr_held : 16'd0;
  assign lambda_out_x1000 = fresh ? lambda_held : 16'd0;
  assign voltage_out_x10 = fresh ? voltage_held : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd_ctl.commit) frame_accepted <= !is_tick && pass;
  end

endmodule

// ===== hdl/cwad_controller.sv =====
// ----------------------------------------------------------------------------
// cwad_controller: sequencer for one transaction at a time
// Steps through capture, multiply/divide (accepted frames only), commit, hold.
// ----------------------------------------------------------------------------
module cwad_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cwad_pkg::cwad_cmd_t   cmd_ctl,
  input  cwad_pkg::cwad_stat_t  stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_WAIT1 = 4'd4;
  localparam logic [3:0] S_AFR  = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_WAIT2 = 4'd8;
  localparam logic [3:0] S_COMMIT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd_ctl = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd_ctl.load = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd_ctl.mul1 = 1'b1;
        state_next = (stat.is_tick || !stat.pass) ? S_COMMIT : S_MUL2;
      end
      S_MUL2: begin
        cmd_ctl.mul2 = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd_ctl.div_start = 1'b1;
        state_next = S_WAIT1;
      end
      S_WAIT1: if (stat.div_done) state_next = S_AFR;
      S_AFR: begin
        cmd_ctl.afr_set = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd_ctl.mul3 = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd_ctl.div2_start = 1'b1;
        state_next = S_WAIT2;
      end
      S_WAIT2: if (stat.div_done) state_next = S_COMMIT;
      S_COMMIT: begin
        cmd_ctl.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_commit: assert property (@(posedge clk) disable iff (rst)
    cmd_ctl.commit |=> out_valid)
    else $error("commit without result");

endmodule

// ===== hdl/can_wideband_afr_decoder.sv =====
// ----------------------------------------------------------------------------
// can_wideband_afr_decoder: CAN wideband AFR decoder top level
// Filters frames, scales the raw word to AFR and lambda, ages on ticks.
// ----------------------------------------------------------------------------
// One transaction at a time: a tick or rejected frame goes straight to commit
// and then has its result offered; an accepted frame first makes two passes
// through the shared 43-step bit-serial divider. The input is ready again in
// the cycle after the result is taken. Configuration writes are taken every
// cycle and must only occur while idle.
module can_wideband_afr_decoder #(
  parameter int AFR_OFFSET = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic        frame_extended,
  input  logic        frame_remote,
  input  logic [28:0] frame_identifier,
  input  logic [3:0]  length_code,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] afr_out_x100,
  output logic [15:0] lambda_out_x1000,
  output logic [7:0]  voltage_out_x10,
  output logic [1:0]  status,
  output logic        frame_accepted
);

  cwad_pkg::cwad_cmd_t  cmd_ctl;
  cwad_pkg::cwad_stat_t stat;

  assign cfg_ready = 1'b1;

  cwad_controller u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd_ctl(cmd_ctl), .stat(stat)
  );

  cwad_datapath #(.AFR_OFFSET(AFR_OFFSET)) u_dp (
    .clk(clk), .rst(rst), .cmd_ctl(cmd_ctl), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .frame_extended(frame_extended), .frame_remote(frame_remote),
    .frame_identifier(frame_identifier), .length_code(length_code),
    .payload(payload), .afr_out_x100(afr_out_x100),
    .lambda_out_x1000(lambda_out_x1000), .voltage_out_x10(voltage_out_x10),
    .status(status), .frame_accepted(frame_accepted)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the CAN wideband AFR decoder
// Drives frames and ticks through valid/ready with random gaps and output
// stalls, predicts the AFR, lambda, voltage and status of every transaction,
// and compares each result in order, across several register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam int   AFR_OFFSET = 0;

  typedef struct {
    logic        cmd;
    logic        ext;
    logic        rtr;
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    int          gap;
  } frame_item_t;

  typedef struct {
    logic [15:0] afr;
    logic [15:0] lam;
    logic [7:0]  volt;
    logic [1:0]  st;
    logic        acc;
  } afr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic frame_extended = 1'b0;
  logic frame_remote = 1'b0;
  logic [28:0] frame_identifier = '0;
  logic [3:0] length_code = '0;
  logic [63:0] payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] afr_out_x100;
  logic [15:0] lambda_out_x1000;
  logic [7:0] voltage_out_x10;
  logic [1:0] status;
  logic frame_accepted;

  can_wideband_afr_decoder #(.AFR_OFFSET(AFR_OFFSET)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [28:0] m_id;
  logic [2:0]  m_off;
  logic        m_ext;
  logic [1:0]  m_fmt;
  logic [19:0] m_num;
  logic [23:0] m_den;
  logic [15:0] m_stoich;
  logic [15:0] m_tmo;
  logic [15:0] h_afr, h_lam, age;
  logic [7:0]  h_volt;
  logic        seen;

  frame_item_t pending[$];
  afr_result_t expected_results[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_acc = 0, n_stale = 0;
  logic tx_busy = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;

  function automatic logic [7:0] byte_of(logic [63:0] d, int k);
    return d[8*(k%8) +: 8];
  endfunction

  function automatic afr_result_t decode_item(frame_item_t it);
    afr_result_t r;
    int unsigned ln;
    int unsigned need;
    logic [15:0] raw;
    longint q;
    longint unsigned prod;
    longint unsigned den;
    r.acc = 1'b0;
    if (it.cmd == CMD_TICK) begin
      if (age != 16'hFFFF) age = age + 16'd1;
    end else begin
      ln = (it.len > 4'd8) ? 32'd8 : 32'(it.len);
      need = 32'(m_off) + (m_fmt[0] ? 32'd2 : 32'd1);
      if (it.ext == m_ext && it.id == m_id && !it.rtr && need <= ln) begin
        if (m_fmt[0])
          raw = m_fmt[1] ? {byte_of(it.data, int'(m_off)), byte_of(it.data, int'(m_off) + 1)}
                         : {byte_of(it.data, int'(m_off) + 1), byte_of(it.data, int'(m_off))};
        else
          raw = {8'h00, byte_of(it.data, int'(m_off))};
        den = (m_den == 24'd0) ? 64'd1 : 64'(m_den);
        prod = 64'(raw) * 64'(m_num) * 64'd100;
        q = longint'(prod / den) + longint'(AFR_OFFSET);
        h_afr = (q <= 0) ? 16'd0 : (q > 65535) ? 16'hFFFF : q[15:0];
        if (h_afr == 16'd0 || m_stoich == 16'd0) h_lam = 16'd0;
        else begin
          q = longint'((64'(h_afr) * 64'd1000) / 64'(m_stoich));
          h_lam = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        h_volt = (ln >= 32'd5) ? byte_of(it.data, 4) : 8'd0;
        age = 16'd0;
        seen = 1'b1;
        r.acc = 1'b1;
      end
    end
    if (!seen) r.st = cwad_pkg::STATUS_NONE;
    else if (age >= m_tmo) r.st = cwad_pkg::STATUS_STALE;
    else r.st = cwad_pkg::STATUS_FRESH;
    r.afr = (r.st == cwad_pkg::STATUS_FRESH) ? h_afr : 16'd0;
    r.lam = (r.st == cwad_pkg::STATUS_FRESH) ? h_lam : 16'd0;
    r.volt = (r.st == cwad_pkg::STATUS_FRESH) ? h_volt : 8'd0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_item(pending.pop_front()));
        n_sent++;
        tx_busy = 1'b0;
      end
      if (!tx_busy && pending.size() > 0) begin
        tx_busy = 1'b1;
        tx_wait = pending[0].gap;
      end
      if (tx_busy && !(in_valid && !in_ready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          cmd <= pending[0].cmd;
          frame_extended <= pending[0].ext;
          frame_remote <= pending[0].rtr;
          frame_identifier <= pending[0].id;
          length_code <= pending[0].len;
          payload <= pending[0].data;
        end
      end else if (!tx_busy) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    afr_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_got++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result afr=%0d status=%0d", $time, afr_out_x100, status);
        end else begin
          e = expected_results.pop_front();
          if (frame_accepted) n_acc++;
          if (status == cwad_pkg::STATUS_STALE) n_stale++;
          if (afr_out_x100 !== e.afr || lambda_out_x1000 !== e.lam ||
              voltage_out_x10 !== e.volt || status !== e.st || frame_accepted !== e.acc) begin
            errors++;
            $display("%0t: mismatch expected afr=%0d lam=%0d v=%0d st=%0d acc=%0d", $time,
                     e.afr, e.lam, e.volt, e.st, e.acc);
            $display("%0t:          actual afr=%0d lam=%0d v=%0d st=%0d acc=%0d", $time,
                     afr_out_x100, lambda_out_x1000, voltage_out_x10, status, frame_accepted);
          end
        end
        rx_wait = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cwad_pkg::REG_MATCH_ID:   m_id = val[28:0];
      cwad_pkg::REG_WORD_OFF:   m_off = val[2:0];
      cwad_pkg::REG_EXPECT_EXT: m_ext = val[0];
      cwad_pkg::REG_WORD_FMT:   m_fmt = val[1:0];
      cwad_pkg::REG_SCALE_NUM:  m_num = val[19:0];
      cwad_pkg::REG_SCALE_DEN:  m_den = val[23:0];
      cwad_pkg::REG_STOICH:     m_stoich = val[15:0];
      cwad_pkg::REG_TIMEOUT:    m_tmo = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic add_item(logic c, logic e, logic r, logic [28:0] i, logic [3:0] l,
                          logic [63:0] d);
    frame_item_t it;
    it.cmd = c; it.ext = e; it.rtr = r; it.id = i; it.len = l; it.data = d;
    it.gap = draw_gap();
    pending.push_back(it);
  endtask

  task automatic drain();
    while (pending.size() > 0 || tx_busy || expected_results.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count);
    int k;
    logic [28:0] id;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:
          add_item(CMD_TICK, 1'($urandom), 1'($urandom), 29'($urandom), 4'($urandom),
                   rand64());
        3: begin
          id = 29'($urandom);
          add_item(CMD_FRAME, 1'($urandom), 1'($urandom), id, 4'($urandom), rand64());
        end
        4:
          add_item(CMD_FRAME, m_ext, $urandom_range(0, 3) == 0,
                   m_id ^ (29'd1 << $urandom_range(0, 28)),
                   4'($urandom_range(0, 15)), rand64());
        default:
          add_item(CMD_FRAME, m_ext, $urandom_range(0, 9) == 0, m_id,
                   4'($urandom_range(0, 15)), rand64());
      endcase
    end
  endtask

  initial begin
    int p;
    m_id = 29'd175; m_off = 3'd0; m_ext = 1'b1; m_fmt = 2'd3;
    m_num = 20'd1465; m_den = 24'd1000000; m_stoich = 16'd1465; m_tmo = 16'd2000;
    h_afr = 16'd0; h_lam = 16'd0; h_volt = 8'd0; age = 16'd0; seen = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, before and after first data
    add_item(CMD_TICK, 1'b1, 1'b1, '1, 4'hF, '1);
    add_item(CMD_FRAME, 1'b1, 1'b0, 29'd175, 4'd8, 64'h0000_00FF_0000_FFFF);
    add_item(CMD_FRAME, 1'b1, 1'b1, 29'd175, 4'd8, '1);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'd175, 4'd8, '1);
    add_item(CMD_FRAME, 1'b1, 1'b0, 29'd174, 4'd8, '1);
    add_item(CMD_FRAME, 1'b1, 1'b0, 29'd175, 4'd1, '1);
    add_item(CMD_FRAME, 1'b1, 1'b0, 29'd175, 4'd15, 64'h1234_5678_9ABC_DEF0);
    add_item(CMD_FRAME, 1'b1, 1'b0, 29'd175, 4'd4, 64'h0000_0000_0000_0000);
    drain();

    write_reg(cwad_pkg::REG_WORD_OFF, 32'd7);
    write_reg(cwad_pkg::REG_WORD_FMT, 32'd1);
    write_reg(cwad_pkg::REG_EXPECT_EXT, 32'd0);
    write_reg(cwad_pkg::REG_MATCH_ID, 32'h1FFF_FFFF);
    write_reg(cwad_pkg::REG_TIMEOUT, 32'd3);
    write_reg(cwad_pkg::REG_STOICH, 32'd0);
    write_reg(cwad_pkg::REG_SCALE_NUM, 32'hFFFFF);
    write_reg(cwad_pkg::REG_SCALE_DEN, 32'd1);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, '1);
    drain();
    write_reg(cwad_pkg::REG_WORD_FMT, 32'd0);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, '1);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd7, '1);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, 64'h00FF_FFFF_FFFF_FFFF);
    repeat (4) add_item(CMD_TICK, 1'b0, 1'b0, 29'd0, 4'd0, 64'd0);
    drain();
    write_reg(cwad_pkg::REG_TIMEOUT, 32'd0);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, '1);
    drain();
    write_reg(cwad_pkg::REG_SCALE_NUM, 32'd0);
    write_reg(cwad_pkg::REG_TIMEOUT, 32'hFFFF);
    write_reg(cwad_pkg::REG_STOICH, 32'd1);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, '1);
    drain();
    write_reg(cwad_pkg::REG_SCALE_DEN, 32'd0);
    write_reg(cwad_pkg::REG_SCALE_NUM, 32'd3);
    add_item(CMD_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, 64'h8000_0000_0000_0000);
    drain();

    for (p = 0; p < 6; p++) begin
      write_reg(cwad_pkg::REG_MATCH_ID, $urandom);
      write_reg(cwad_pkg::REG_WORD_OFF, $urandom);
      write_reg(cwad_pkg::REG_EXPECT_EXT, $urandom);
      write_reg(cwad_pkg::REG_WORD_FMT, $urandom);
      write_reg(cwad_pkg::REG_SCALE_NUM, p == 0 ? 32'hFFFFF : $urandom_range(0, 4000));
      write_reg(cwad_pkg::REG_SCALE_DEN, p == 1 ? 32'hFFFFFF : $urandom_range(1, 2000000));
      write_reg(cwad_pkg::REG_STOICH, p == 2 ? 32'hFFFF : $urandom_range(0, 3000));
      write_reg(cwad_pkg::REG_TIMEOUT, p == 3 ? 32'd1 : $urandom_range(1, 40));
      random_phase(200);
      drain();
    end

    $display("Sent %0d transactions, %0d results, %0d frames accepted, %0d stale.",
             n_sent, n_got, n_acc, n_stale);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/cwad_pkg.sv
hdl/cwad_divider.sv
hdl/cwad_datapath.sv
hdl/cwad_controller.sv
hdl/can_wideband_afr_decoder.sv
verif/tb.sv
